// ----- rtl/sabs_pkg.sv -----
// Shared types and codes for the sorted-array search block.
// No dependencies; imported by the RAM, the controller, the top level, the checker and the testbench.
`default_nettype none

package sabs_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_EXACT  = 2'd1,
    CMD_LEFT   = 2'd2,
    CMD_RIGHT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/sabs_ram.sv -----
// Element store: single-port-write, single-port-read synchronous RAM.
// Read data is registered: it appears in the cycle after the address. Uses sabs_pkg for the data width.
`default_nettype none

module sabs_ram
  import sabs_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic signed [VALUE_W-1:0]  wdata,
  input  wire logic [AW-1:0]              raddr,
  output logic signed [VALUE_W-1:0]       rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/sabs_ctrl.sv -----
// Request sequencer: append handling, element count and the binary-search
// probe loop over sabs_ram. Depends on sabs_pkg.
`default_nettype none

module sabs_ctrl
  import sabs_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 cmd,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic                       restart,
  output logic                            done,
  output status_t                         status,
  output logic [INDEX_W-1:0]              index,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic signed [VALUE_W-1:0]       ram_wdata,
  output logic [AW-1:0]                   ram_raddr,
  input  wire logic signed [VALUE_W-1:0]  ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_FINAL} state_t;

  state_t                    state;
  cmd_t                      mode;
  logic signed [VALUE_W-1:0] target;
  logic [CW-1:0]             count;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi;
  logic [AW-1:0]             mid;

  logic                      go_right;
  logic                      hit;
  logic [CW-1:0]             lo_next;
  logic [CW-1:0]             hi_next;
  logic [CW-1:0]             span;
  logic [AW-1:0]             mid_next;
  logic [AW-1:0]             first_mid;
  logic                      more;
  logic                      accept;

  assign busy   = rst || (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    hit      = (ram_rdata == target);
    go_right = (mode == CMD_RIGHT) ? (ram_rdata <= target) : (ram_rdata < target);
    lo_next  = lo;
    hi_next  = hi;
    if (go_right) begin
      lo_next = CW'(mid) + CW'(1);
    end else begin
      hi_next = CW'(mid);
    end
    more = (lo_next < hi_next);
    span = hi_next - lo_next;
    if (mode == CMD_EXACT) begin
      span = span - CW'(1);
    end
    mid_next  = AW'(lo_next + (span >> 1));
    first_mid = (cmd_t'(cmd) == CMD_EXACT) ? AW'((count - CW'(1)) >> 1) : AW'(count >> 1);
  end

  // Read address is issued in the cycle before the compare that uses it.
  always_comb begin
    unique case (state)
      S_IDLE:  ram_raddr = first_mid;
      S_PROBE: begin
        if (more) begin
          ram_raddr = mid_next;
        end else if (mode == CMD_RIGHT) begin
          ram_raddr = AW'(lo_next - CW'(1));
        end else begin
          ram_raddr = AW'(lo_next);
        end
      end
      S_FINAL: ram_raddr = mid;
      default: ram_raddr = mid;
    endcase
  end

  assign ram_we    = accept && (cmd_t'(cmd) == CMD_APPEND) && (restart || (count < CW'(DEPTH)));
  assign ram_waddr = restart ? '0 : AW'(count);
  assign ram_wdata = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd_t'(cmd) == CMD_APPEND) begin
              done <= 1'b1;
              if (restart) begin
                count  <= CW'(1);
                status <= ST_OK;
                index  <= '0;
              end else if (count >= CW'(DEPTH)) begin
                status <= ST_FULL;
                index  <= '0;
              end else begin
                count  <= count + CW'(1);
                status <= ST_OK;
                index  <= INDEX_W'(count);
              end
            end else if (count == '0) begin
              done   <= 1'b1;
              status <= ST_MISS;
              index  <= '0;
            end else begin
              mode   <= cmd_t'(cmd);
              target <= value;
              lo     <= '0;
              hi     <= count;
              mid    <= first_mid;
              state  <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if ((mode == CMD_EXACT) && hit) begin
            done   <= 1'b1;
            status <= ST_OK;
            index  <= INDEX_W'(mid);
            state  <= S_IDLE;
          end else if (more) begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next;
          end else if ((mode == CMD_LEFT) && (lo_next < count)) begin
            mid   <= AW'(lo_next);
            state <= S_FINAL;
          end else if ((mode == CMD_RIGHT) && (lo_next != '0)) begin
            mid   <= AW'(lo_next - CW'(1));
            state <= S_FINAL;
          end else begin
            done   <= 1'b1;
            status <= ST_MISS;
            index  <= '0;
            state  <= S_IDLE;
          end
        end
        S_FINAL: begin
          done   <= 1'b1;
          status <= hit ? ST_OK : ST_MISS;
          index  <= hit ? INDEX_W'(mid) : '0;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_array_binary_search.sv -----
// Top level of the sorted-array search block: sequencer plus element RAM.
// Depends on sabs_pkg, sabs_ram and sabs_ctrl.
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ---------------------------
//   request   start && !busy          cmd, value, restart
//   result    done (one-cycle strobe) status, index
//
// Cycles: an append is answered on done in the cycle after it is taken and
// busy stays low, so a new request may follow at once. A search over n
// elements takes about log2(n)+1 probes, plus one extra read for leftmost
// and rightmost modes. In the probe loop, each compare uses the RAM read
// data and issues the next address. Reset empties the array at once (the
// element count is cleared); there is no clearing pass. The receiver cannot
// stall: each result is offered on done for exactly one cycle, and busy
// falls in that same cycle.
`default_nettype none

module sorted_array_binary_search
  import sabs_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 cmd,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic                       restart,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [INDEX_W-1:0]              index
);

  // Address width for the store, count width wide enough to hold DEPTH itself.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic signed [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic signed [VALUE_W-1:0] ram_rdata;
  status_t                   status_code;

  // Sequencer: takes requests, keeps the element count, runs the probe loop.
  sabs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .value     (value),
    .restart   (restart),
    .done      (done),
    .status    (status_code),
    .index     (index),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Element store; searches never use an entry at or above the count.
  sabs_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status = status_code;

endmodule

`default_nettype wire

// ----- rtl/sabs_checker.sv -----
// Port-level checker for sorted_array_binary_search, attached by bind.
// Depends on sabs_pkg.
`default_nettype none

module sabs_checker
  import sabs_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [1:0]          cmd,
  input wire logic                restart,
  input wire logic                done,
  input wire logic [1:0]          status,
  input wire logic [INDEX_W-1:0]  index
);

  // An append is always answered in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_APPEND)) |=> done)
    else $error("append request not answered in the next cycle");

  // A miss or a dropped append carries index zero.
  assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (index == '0))
    else $error("non-zero index on a failed request");

  // Full can only answer an append without restart taken the cycle before.
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |->
      $past(!rst && start && !busy && (cmd == CMD_APPEND) && !restart))
    else $error("full status without a matching append");

  // Busy rises only after a search request is taken.
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(!rst && start && !busy && (cmd != CMD_APPEND)))
    else $error("busy raised without a search request");

endmodule

bind sorted_array_binary_search sabs_checker u_sabs_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .cmd     (cmd),
  .restart (restart),
  .done    (done),
  .status  (status),
  .index   (index)
);

`default_nettype wire

// ----- test/tb_sorted_array_binary_search.sv -----
// Self-checking testbench for sorted_array_binary_search: appends, exact, leftmost and
// rightmost searches against an in-bench search model, with random sender gaps.
// Depends on sabs_pkg and the RTL of the block.
module tb_sorted_array_binary_search;
  import sabs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;

  // One answer of the block: what a request should report back.
  typedef struct {
    status_t             status;
    logic [INDEX_W-1:0]  index;
  } answer_t;

  // Drive every input to a known value from time zero.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [1:0]                 cmd = CMD_APPEND;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       restart = 1'b0;
  wire logic                  busy;
  wire logic                  done;
  wire logic [1:0]            status;
  wire logic [INDEX_W-1:0]    index;

  // Search model: its own copy of the array and the element count.
  logic signed [VALUE_W-1:0]  model_elems [DEPTH];
  int unsigned                model_count = 0;

  answer_t      expected_answers [$];
  answer_t      oldest_answer;
  int unsigned  requests_sent = 0;
  int unsigned  error_count = 0;
  bit           gaps_on = 1'b0;

  sorted_array_binary_search #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .value(value),
    .restart(restart),
    .done(done),
    .status(status),
    .index(index)
  );

  always #6 clk = ~clk;

  // Work out the answer to one accepted request and update the model state.
  // Searches only look below the element count, so stale entries are never read.
  function automatic void predict_answer(input cmd_t op,
                                         input logic signed [VALUE_W-1:0] target,
                                         input logic wipe, output answer_t ans);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    ans.status = ST_MISS;
    ans.index  = '0;
    if (op == CMD_APPEND) begin
      if (wipe) model_count = 0;
      if (model_count >= DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        model_elems[model_count] = target;
        ans.status = ST_OK;
        ans.index  = INDEX_W'(model_count);
        model_count++;
      end
      return;
    end
    // An empty array answers not-found without touching the store.
    if (model_count == 0) return;
    lo = 0;
    hi = model_count;
    case (op)
      CMD_EXACT: begin
        // Midpoint rounded down over the closed range; stop at the first hit.
        while (lo < hi) begin
          mid = lo + (hi - 1 - lo) / 2;
          if (model_elems[mid] == target) begin
            ans.status = ST_OK;
            ans.index  = INDEX_W'(mid);
            return;
          end
          if (model_elems[mid] < target) lo = mid + 1;
          else hi = mid;
        end
      end
      CMD_LEFT: begin
        // Lower bound: first position not below the target.
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (model_elems[mid] < target) lo = mid + 1;
          else hi = mid;
        end
        if (lo < model_count && model_elems[lo] == target) begin
          ans.status = ST_OK;
          ans.index  = INDEX_W'(lo);
        end
      end
      default: begin
        // Upper bound: first position above the target, then step back one.
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (model_elems[mid] <= target) lo = mid + 1;
          else hi = mid;
        end
        if (lo > 0 && model_elems[lo - 1] == target) begin
          ans.status = ST_OK;
          ans.index  = INDEX_W'(lo - 1);
        end
      end
    endcase
  endfunction

  // Sorted fill for the full-array test: pairs of equal values, spanning most of the range.
  function automatic logic signed [VALUE_W-1:0] fill_value(input int unsigned pos);
    return VALUE_W'(longint'(pos / 2) * 6000000 - 1500000000);
  endfunction

  // Drop start and hold the sender off for a number of cycles.
  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Present one request and wait until the block takes it. Start is left high so that
  // a following request goes out back to back; hold_off or the drain lowers it.
  task automatic issue_request(input cmd_t op, input logic signed [VALUE_W-1:0] operand,
                               input logic wipe);
    answer_t ans;
    if (gaps_on && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 10));
    start   <= 1'b1;
    cmd     <= op;
    value   <= operand;
    restart <= wipe;
    do @(posedge clk); while (busy);
    predict_answer(op, operand, wipe, ans);
    expected_answers.push_back(ans);
    requests_sent++;
  endtask

  // Stop sending and wait until every outstanding answer has come back.
  task automatic drain_answers();
    start <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // Searches on the array as it is after reset: all must miss.
  task automatic test_empty_array();
    issue_request(CMD_EXACT, 32'sh8000_0000, 1'b0);
    issue_request(CMD_LEFT, 32'sd0, 1'b1);
    issue_request(CMD_RIGHT, 32'sh7fff_ffff, 1'b0);
  endtask

  // Small sorted array with both extremes and a run of duplicates.
  task automatic test_small_sorted();
    issue_request(CMD_APPEND, 32'sh8000_0000, 1'b1);
    issue_request(CMD_APPEND, -32'sd1, 1'b0);
    issue_request(CMD_APPEND, 32'sd0, 1'b0);
    issue_request(CMD_APPEND, 32'sd0, 1'b0);
    issue_request(CMD_APPEND, 32'sd0, 1'b0);
    issue_request(CMD_APPEND, 32'sd5, 1'b0);
    issue_request(CMD_APPEND, 32'sh7fff_ffff, 1'b0);
    issue_request(CMD_EXACT, 32'sd0, 1'b0);
    issue_request(CMD_LEFT, 32'sd0, 1'b0);
    issue_request(CMD_RIGHT, 32'sd0, 1'b1);
    issue_request(CMD_LEFT, 32'sh8000_0000, 1'b0);
    issue_request(CMD_RIGHT, 32'sh7fff_ffff, 1'b0);
    issue_request(CMD_EXACT, 32'sh7fff_ffff, 1'b0);
    issue_request(CMD_EXACT, 32'sd3, 1'b0);
    issue_request(CMD_LEFT, 32'sh7fff_fffe, 1'b0);
    issue_request(CMD_RIGHT, 32'sh8000_0001, 1'b0);
  endtask

  // Out-of-order contents: the probe sequence still decides the answer.
  task automatic test_unsorted_contents();
    issue_request(CMD_APPEND, 32'sd9, 1'b1);
    issue_request(CMD_APPEND, 32'sd3, 1'b0);
    issue_request(CMD_APPEND, 32'sd7, 1'b0);
    issue_request(CMD_EXACT, 32'sd3, 1'b0);
    issue_request(CMD_LEFT, 32'sd7, 1'b0);
    issue_request(CMD_RIGHT, 32'sd9, 1'b0);
  endtask

  // Fill to capacity, search the full array, overflow it, then restart on a full array.
  task automatic test_full_array();
    int unsigned pos;
    for (int unsigned i = 0; i < DEPTH; i++) issue_request(CMD_APPEND, fill_value(i), i == 0);
    issue_request(CMD_EXACT, fill_value(0), 1'b0);
    issue_request(CMD_RIGHT, fill_value(DEPTH - 1), 1'b0);
    repeat (14) begin
      pos = $urandom_range(0, DEPTH - 1);
      issue_request(cmd_t'($urandom_range(1, 3)),
                    fill_value(pos) + ($urandom_range(0, 2) == 0), $urandom_range(0, 1));
    end
    // Let the array settle before the overflow appends.
    drain_answers();
    issue_request(CMD_APPEND, 32'sd1, 1'b0);
    issue_request(CMD_APPEND, 32'sh7fff_ffff, 1'b0);
    issue_request(CMD_LEFT, fill_value(DEPTH - 1), 1'b0);
    issue_request(CMD_APPEND, -32'sd42, 1'b1);
    issue_request(CMD_EXACT, -32'sd42, 1'b0);
  endtask

  // Random sets: restart, append a mostly ascending run with duplicates, then search it,
  // mostly for values present. A few sets carry out-of-order entries or skip the restart.
  task automatic test_random_sets(input int unsigned item_goal);
    logic signed [VALUE_W-1:0] set_vals [$];
    logic signed [VALUE_W-1:0] target;
    longint                    running;
    int unsigned               set_len;
    int unsigned               pick;
    int unsigned               quiet_from;
    quiet_from = requests_sent + item_goal * 3 / 4;
    item_goal += requests_sent;
    while (requests_sent < item_goal) begin
      // Gaps come and go per set, and stop for the last quarter.
      gaps_on = (requests_sent < quiet_from) && ($urandom_range(0, 3) != 0);
      set_vals.delete();
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      running = ($urandom_range(0, 3) == 0) ? -64'sd2147483648 : longint'(int'($urandom));
      for (int unsigned i = 0; i < set_len; i++) begin
        case ($urandom_range(0, 3))
          0: running = running;
          1: running = running + $urandom_range(1, 3);
          2: running = running + $urandom_range(1, 1 << 20);
          default: running = running + $urandom_range(0, 32'h7fff_ffff);
        endcase
        if (running > 64'sd2147483647) running = 64'sd2147483647;
        if ($urandom_range(0, 11) == 0) set_vals.push_back($urandom);
        else set_vals.push_back(running[VALUE_W-1:0]);
      end
      foreach (set_vals[i]) begin
        issue_request(CMD_APPEND, set_vals[i],
                      (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0));
      end
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, set_vals.size() - 1);
        case ($urandom_range(0, 9))
          0, 1: target = $urandom;
          2: target = set_vals[pick] + 1;
          3: target = set_vals[pick] - 1;
          default: target = set_vals[pick];
        endcase
        issue_request(cmd_t'($urandom_range(1, 3)), target, $urandom_range(0, 1));
      end
    end
    gaps_on = 1'b0;
  endtask

  // Compare each answer with the oldest expectation. Sample mid-cycle: the strobe and
  // payload are stable then, and expectations are pushed at the accepting edge before.
  always @(negedge clk) begin
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        error_count++;
        $display("%0t: unexpected answer status=%0d index=%0d", $realtime, status, index);
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (status !== oldest_answer.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $realtime, oldest_answer.status, status);
        end
        if (index !== oldest_answer.index) begin
          error_count++;
          $display("%0t: index mismatch: expected %0d, actual %0d",
                   $realtime, oldest_answer.index, index);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_array();
    test_small_sorted();
    drain_answers();
    test_unsorted_contents();
    gaps_on = 1'b1;
    test_full_array();
    test_random_sets(800);
    drain_answers();
    // Give a stray answer time to show up.
    repeat (30) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("** sorted_array_binary_search: PASSED **");
    end else begin
      $display("** sorted_array_binary_search: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("%0t: timeout", $realtime);
    $display("** sorted_array_binary_search: FAILED **");
    $finish;
  end

endmodule
